@@ rtl/ilp_pkg.sv @@
package ilp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_OCT = 2'd3
  } base_t;

  typedef enum logic [1:0] {
    PH_SIGN   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_ZERO   = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       begin_req;
    logic       text_end;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        consumed_chars;
    logic [1:0]         base_used;
    logic               char_left_over;
  } out_t;

  // classified character, indexed digit-valid flags by base_t
  typedef struct packed {
    logic       is_minus;
    logic       is_zero;
    logic       is_under;
    logic       is_pfx;
    base_t      pfx_base;
    logic [3:0] dval;
    logic [3:0] dig_ok;
    logic       begin_req;
    logic       text_end;
  } cls_t;

endpackage

@@ rtl/ilp_front.sv @@
module ilp_front (
  input  ilp_pkg::in_t  in_data,
  output ilp_pkg::cls_t cls
);

  logic [7:0] lc;
  logic       is_dec;

  always_comb begin
    lc     = in_data.ch | ilp_pkg::CASE_BIT;
    is_dec = (in_data.ch >= ilp_pkg::CH_ZERO) && (in_data.ch <= ilp_pkg::CH_NINE);

    cls.is_minus  = (in_data.ch == ilp_pkg::CH_MINUS);
    cls.is_zero   = (in_data.ch == ilp_pkg::CH_ZERO);
    cls.is_under  = (in_data.ch == ilp_pkg::CH_UNDER);
    cls.is_pfx    = (in_data.ch == ilp_pkg::CH_X) || (in_data.ch == ilp_pkg::CH_B) ||
                    (in_data.ch == ilp_pkg::CH_O);
    cls.pfx_base  = (in_data.ch == ilp_pkg::CH_X) ? ilp_pkg::BASE_HEX :
                    (in_data.ch == ilp_pkg::CH_B) ? ilp_pkg::BASE_BIN : ilp_pkg::BASE_OCT;
    // letters a-f: low nibble 1..6 maps to 10..15
    cls.dval      = is_dec ? in_data.ch[3:0] : 4'(in_data.ch[3:0] + 4'd9);

    cls.dig_ok[ilp_pkg::BASE_DEC] = is_dec;
    cls.dig_ok[ilp_pkg::BASE_HEX] = is_dec ||
                                    ((lc >= ilp_pkg::CH_LA) && (lc <= ilp_pkg::CH_LF));
    cls.dig_ok[ilp_pkg::BASE_BIN] = (in_data.ch == ilp_pkg::CH_ZERO) ||
                                    (in_data.ch == ilp_pkg::CH_ONE);
    cls.dig_ok[ilp_pkg::BASE_OCT] = (in_data.ch >= ilp_pkg::CH_ZERO) &&
                                    (in_data.ch <= ilp_pkg::CH_SEVEN);

    cls.begin_req = in_data.begin_req;
    cls.text_end  = in_data.text_end;
  end

endmodule

@@ rtl/ilp_queue.sv @@
module ilp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ilp_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output ilp_pkg::cls_t q_data
);

  // two entries, one-bit pointers
  ilp_pkg::cls_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  always_comb begin
    full       = (count_r == 2'd2);
    q_valid    = (count_r != 2'd0);
    q_data     = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = 2'(count_r + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0) else $error("pop from empty queue");

endmodule

@@ rtl/ilp_back.sv @@
module ilp_back #(
  parameter int unsigned VALUE_BITS = ilp_pkg::VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = ilp_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ilp_pkg::cls_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ilp_pkg::out_t out_data
);

  logic                  active_r, active_nxt;
  ilp_pkg::phase_t       phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  ilp_pkg::base_t        sel_r, sel_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r;
  ilp_pkg::out_t         out_data_r;

  logic                  act_v, used, done, emit;
  ilp_pkg::phase_t       ph_v;
  logic                  neg_v;
  ilp_pkg::base_t        sel_v;
  logic [VALUE_BITS-1:0] acc_v, scaled, res_v;
  logic [COUNT_BITS-1:0] cnt_v;
  logic signed [63:0]    res_ext;
  logic [31:0]           cnt_ext;
  ilp_pkg::out_t         res;

  always_comb begin
    act_v = q_data.begin_req | active_r;
    ph_v  = q_data.begin_req ? ilp_pkg::PH_SIGN  : phase_r;
    neg_v = q_data.begin_req ? 1'b0              : neg_r;
    sel_v = q_data.begin_req ? ilp_pkg::BASE_DEC : sel_r;
    acc_v = q_data.begin_req ? '0                : acc_r;
    cnt_v = q_data.begin_req ? '0                : cnt_r;
    used  = 1'b0;
    done  = 1'b0;

    if (act_v) begin
      if (ph_v == ilp_pkg::PH_SIGN) begin
        ph_v = ilp_pkg::PH_LEAD;
        if (q_data.is_minus) begin
          neg_v = 1'b1;
          used  = 1'b1;
          done  = 1'b1;
        end
      end
      if (!done && ph_v == ilp_pkg::PH_LEAD) begin
        if (q_data.is_zero) begin
          ph_v  = ilp_pkg::PH_ZERO;
          acc_v = '0;
          used  = 1'b1;
          done  = 1'b1;
        end else begin
          ph_v = ilp_pkg::PH_DIGITS;
        end
      end
      if (!done && ph_v == ilp_pkg::PH_ZERO) begin
        ph_v = ilp_pkg::PH_DIGITS;
        if (!q_data.text_end && q_data.is_pfx) begin
          sel_v = q_data.pfx_base;
          acc_v = '0;
          used  = 1'b1;
          done  = 1'b1;
        end
      end
      if (!done) begin
        if (q_data.is_under) begin
          used = 1'b1;
        end else if (q_data.dig_ok[sel_v]) begin
          used = 1'b1;
        end
      end
    end

    case (sel_v)
      ilp_pkg::BASE_DEC: scaled = (acc_v << 3) + (acc_v << 1);
      ilp_pkg::BASE_HEX: scaled = acc_v << 4;
      ilp_pkg::BASE_BIN: scaled = acc_v << 1;
      ilp_pkg::BASE_OCT: scaled = acc_v << 3;
      default:           scaled = acc_v;
    endcase
    if (act_v && !done && !q_data.is_under && q_data.dig_ok[sel_v]) begin
      acc_v = scaled + VALUE_BITS'(q_data.dval);
    end
    if (used && cnt_v != '1) begin
      cnt_v = COUNT_BITS'(cnt_v + 1'b1);
    end

    emit    = act_v && (!used || q_data.text_end);
    res_v   = neg_v ? VALUE_BITS'(-acc_v) : acc_v;
    res_ext = 64'(signed'(res_v));
    cnt_ext = 32'(cnt_v);
    res.value          = res_ext[31:0];
    res.consumed_chars = cnt_ext[15:0];
    res.base_used      = sel_v;
    res.char_left_over = !used;

    if (emit) begin
      active_nxt = 1'b0;
      phase_nxt  = ilp_pkg::PH_SIGN;
      neg_nxt    = 1'b0;
      sel_nxt    = ilp_pkg::BASE_DEC;
      acc_nxt    = '0;
      cnt_nxt    = '0;
    end else begin
      active_nxt = act_v;
      phase_nxt  = ph_v;
      neg_nxt    = neg_v;
      sel_nxt    = sel_v;
      acc_nxt    = acc_v;
      cnt_nxt    = cnt_v;
    end

    q_pop = q_valid && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r  <= ilp_pkg::PH_SIGN;
      neg_r    <= 1'b0;
      sel_r    <= ilp_pkg::BASE_DEC;
      acc_r    <= '0;
      cnt_r    <= '0;
    end else if (q_pop) begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      sel_r    <= sel_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && emit) |=> (!active_r && phase_r == ilp_pkg::PH_SIGN && out_valid_r))
    else $error("state not cleared after result");

  a_phase_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != ilp_pkg::PH_SIGN || cnt_r != '0) |-> active_r)
    else $error("literal state held while inactive");

  a_base_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (sel_r != ilp_pkg::BASE_DEC) |-> (phase_r == ilp_pkg::PH_DIGITS))
    else $error("base chosen outside digit phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !q_pop)
    else $error("result register overwritten");

endmodule

@@ rtl/integer_literal_parser.sv @@
// channel | dir | ports                            | beat
// in      | in  | in_valid, in_ready, in_data      | ch, begin_req, text_end
// out     | out | out_valid, out_ready, out_data   | value, consumed_chars, base_used,
//         |     |                                  | char_left_over
// One character per cycle sustained while results are read; out_valid rises once the
// character that ends the literal has passed the queue entry, then the result register.
// The back end retires one queued character per cycle while the result register
// is empty or being read.
// Reset is synchronous, active low; clears queue, parser state and out_valid.
// While a result waits on out_ready the two-entry queue takes at most two more beats,
// then in_ready drops until the result is read.
module integer_literal_parser #(
  parameter int unsigned VALUE_BITS = ilp_pkg::VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = ilp_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ilp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ilp_pkg::out_t out_data
);

  ilp_pkg::cls_t cls;
  ilp_pkg::cls_t q_data;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;

  assign in_ready = !q_full;

  ilp_front u_front (
    .in_data (in_data),
    .cls     (cls)
  );

  ilp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ilp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
